[design/fmmn_pkg.sv]
// shared types for the frame min-max normalizer
package fmmn_pkg;

    // sequencer states of the top level
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_FINISH
    } fmmn_state_t;

    // status from the serial divider to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[design/fmmn_ram.sv]
// generic single-port ram with registered read
module fmmn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or registered read, one access per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[design/fmmn_divider.sv]
// restoring divider, one quotient bit per cycle
module fmmn_divider
    import fmmn_pkg::*;
#(
    parameter int W = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [2*W-1:0] numer,
    input  logic [W-1:0]  denom,
    output logic [W-1:0]  quotient,
    output div_status_t   status
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     num_reg, num_next;
    logic [W-1:0]     quot_reg, quot_next;
    logic [W-1:0]     den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic             fits;

    // shift in the next numerator bit and try the subtraction
    assign trial = {rem_reg, num_reg[W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // next-value logic
    always_comb
    begin
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            // high half is below the divisor, so quotient fits in W bits
            rem_next  = numer[2*W-1:W];
            num_next  = numer[W-1:0];
            den_next  = denom;
            quot_next = '0;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? W'(trial - {1'b0, den_reg}) : trial[W-1:0];
            num_next  = {num_reg[W-2:0], 1'b0};
            quot_next = {quot_reg[W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
    end

    assign quotient = quot_reg;
    assign status   = {busy_reg, done_reg};

endmodule

[design/frame_min_max_normalizer.sv]
// top level of the frame min-max normalizer
//
// Loads store one sample per request in a single-port ram and update the
// running minimum and maximum in the same cycle. A fetch reads the next
// stored sample at the edge that takes it and scales it to full range as
// floor((v - min) * (2^SAMPLE_BITS - 1) / (max - min)); its result goes
// through these steps: start the bit-serial restoring divider, run
// SAMPLE_BITS divider steps, capture the quotient and load the output
// register. No new request is taken until the output register is loaded.
// A fetch on a zero-range frame skips the divider, and one on an empty
// frame skips the read as well; a fetch waits while a stalled output
// register still holds a result. The input stalls while a fetch is in
// flight; loads keep being taken while a finished result waits in the
// output register. Loads past MAX_PIXELS are dropped.
module frame_min_max_normalizer
    import fmmn_pkg::*;
#(
    parameter int MAX_PIXELS  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  logic                   command,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   frame_start,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic [SAMPLE_BITS-1:0] normalized_level,
    output logic                   last_of_frame,
    output logic                   no_data
);

    localparam int W  = SAMPLE_BITS;
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam logic [W-1:0]  FULL  = {W{1'b1}};
    localparam logic [CW-1:0] LIMIT = CW'(MAX_PIXELS);

    fmmn_state_t state_reg, state_next;

    logic [W-1:0]  min_reg, min_next;
    logic [W-1:0]  max_reg, max_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [W-1:0]  result_reg, result_next;
    logic          last_reg, last_next;
    logic          empty_reg, empty_next;
    logic          res_valid_reg, res_valid_next;
    logic [W-1:0]  out_level_reg;
    logic          out_last_reg;
    logic          out_empty_reg;

    logic          accept;
    logic          is_load;
    logic          is_fetch;
    logic [W-1:0]  base_min;
    logic [W-1:0]  base_max;
    logic [CW-1:0] base_count;
    logic          room;
    logic [CW-1:0] fetch_idx;
    logic [CW-1:0] fetch_idx_inc;
    logic          fetch_last;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [W-1:0]  ram_rdata;

    logic [W-1:0]  diff;
    logic [W-1:0]  range;
    logic          flat;
    logic [2*W-1:0] numer;
    logic          div_start;
    logic [W-1:0]  quotient;
    div_status_t   div_status;
    logic          out_load;

    assign accept   = cmd_valid && !cmd_stall;
    assign is_load  = accept && !command;
    assign is_fetch = accept && command;

    // frame start clears the running state before the load
    assign base_min   = frame_start ? FULL : min_reg;
    assign base_max   = frame_start ? '0 : max_reg;
    assign base_count = frame_start ? '0 : count_reg;
    assign room       = (base_count < LIMIT);

    // read position wraps when it has run past the frame
    assign fetch_idx     = (rd_idx_reg >= count_reg) ? '0 : rd_idx_reg;
    assign fetch_idx_inc = fetch_idx + CW'(1);
    assign fetch_last    = (fetch_idx_inc >= count_reg);

    // ram port shared by loads and fetches
    assign ram_we   = is_load && room;
    assign ram_addr = is_load ? base_count[AW-1:0] : fetch_idx[AW-1:0];

    fmmn_ram #(
        .WIDTH (W),
        .DEPTH (MAX_PIXELS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (sample),
        .rdata (ram_rdata)
    );

    // scaling operands for the sample just read
    assign diff  = (ram_rdata > min_reg) ? W'(ram_rdata - min_reg) : '0;
    assign flat  = (max_reg <= min_reg);
    assign range = W'(max_reg - min_reg);
    assign numer = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};

    fmmn_divider #(
        .W (W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer),
        .denom    (range),
        .quotient (quotient),
        .status   (div_status)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (is_fetch)
                begin
                    state_next = (count_reg == '0) ? ST_FINISH : ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = flat ? ST_FINISH : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd_stall = 1'b1;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
            end
            ST_READ:
            begin
                div_start = !flat;
            end
            ST_DIV:
            begin
                cmd_stall = 1'b1;
            end
            ST_FINISH:
            begin
                out_load = !res_valid_reg || !res_stall;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // frame bookkeeping and result capture
    always_comb
    begin
        min_next       = min_reg;
        max_next       = max_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        result_next    = result_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        res_valid_next = res_valid_reg;

        if (is_load)
        begin
            min_next   = base_min;
            max_next   = base_max;
            count_next = base_count;
            if (frame_start)
            begin
                rd_idx_next = '0;
            end
            if (room)
            begin
                count_next = base_count + CW'(1);
                if (sample < base_min)
                begin
                    min_next = sample;
                end
                if (sample > base_max)
                begin
                    max_next = sample;
                end
            end
        end

        if (is_fetch)
        begin
            result_next = '0;
            last_next   = 1'b0;
            empty_next  = (count_reg == '0);
            if (count_reg != '0)
            begin
                last_next   = fetch_last;
                rd_idx_next = fetch_last ? '0 : fetch_idx_inc;
            end
        end

        if (state_reg == ST_READ && flat)
        begin
            result_next = diff;
        end

        if (state_reg == ST_DIV && div_status.done)
        begin
            result_next = quotient;
        end

        // output register: taken by the sink or refilled
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (out_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            min_reg       <= FULL;
            max_reg       <= '0;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        last_reg   <= last_next;
        empty_reg  <= empty_next;
        if (out_load)
        begin
            out_level_reg <= result_reg;
            out_last_reg  <= last_reg;
            out_empty_reg <= empty_reg;
        end
    end

    assign res_valid        = res_valid_reg;
    assign normalized_level = out_level_reg;
    assign last_of_frame    = out_last_reg;
    assign no_data          = out_empty_reg;

endmodule
